[design/int_to_ascii_formatter_assert.svh]
// Assertion macros used by the checker file of the formatter.
`ifndef INT_TO_ASCII_FORMATTER_ASSERT_SVH
`define INT_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ITAF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("formatter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ITAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("formatter assertion failed");

`endif

[design/itaf_pkg.sv]
// Package with the widths, character codes and shared types of the formatter.
package itaf_pkg;

  // Operand width after masking.
  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 32;

  // Digit counts for both bases.
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIG_N      = (HEX_DIGITS > DEC_DIGITS) ? HEX_DIGITS : DEC_DIGITS;
  localparam int DIG_W      = DIG_N * 4;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int REM_W      = $clog2(DIG_N + 1);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  // Conversion kinds; the last one produces no text.
  localparam logic [1:0] REQ_CHAR   = 2'd0;
  localparam logic [1:0] REQ_HEX    = 2'd1;
  localparam logic [1:0] REQ_DEC    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Load command from the sequencer to the character emitter.
  typedef struct packed {
    logic       load;
    logic       head_en;
    logic [7:0] head_char;
    logic       dig_en;
    logic       tail_en;
  } itaf_load_t;

  // Maps one digit (0 to 15) to its lower-case ASCII character.
  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_LOWA + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

[design/itaf_dabble.sv]
// Bit-serial binary to BCD converter using the shift and add-3 method.
module itaf_dabble (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [itaf_pkg::VALUE_BITS-1:0]  mag,
  output logic                             done,
  output logic [itaf_pkg::BCD_W-1:0]       bcd
);
  import itaf_pkg::*;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] sh;
  logic [BCD_W-1:0]      adj;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // One operand bit moves into the BCD register per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers for the operand and the digits.
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[VALUE_BITS-2:0], 1'b0};
      bcd <= {adj[BCD_W-2:0], sh[VALUE_BITS-1]};
    end
  end

endmodule

[design/itaf_emit.sv]
// Character emitter: prefix, digits without leading zeros, suffix, output register.
module itaf_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  itaf_pkg::itaf_load_t          ld,
  input  logic [itaf_pkg::DIG_W-1:0]    digits,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char,
  output logic                          last
);
  import itaf_pkg::*;

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_HEAD = 5'b00010,
    E_SKIP = 5'b00100,
    E_DIG  = 5'b01000,
    E_TAIL = 5'b10000
  } phase_t;

  phase_t           phase, phase_next;
  logic [DIG_W-1:0] dig, dig_next;
  logic [REM_W-1:0] rem, rem_next;
  logic [7:0]       head_char, head_char_next;
  logic             head_en, head_en_next;
  logic             dig_en, dig_en_next;
  logic             tail_en, tail_en_next;
  logic             out_valid_next;
  logic [7:0]       out_char_next;
  logic             last_next;
  logic             adv;
  logic [3:0]       top_dig;

  assign idle    = (phase == E_IDLE);
  assign adv     = !out_valid || out_ready;
  assign top_dig = dig[DIG_W-1 -: 4];

  // Phase sequencing and output register loading.
  always_comb begin
    phase_next     = phase;
    dig_next       = dig;
    rem_next       = rem;
    head_char_next = head_char;
    head_en_next   = head_en;
    dig_en_next    = dig_en;
    tail_en_next   = tail_en;
    out_valid_next = out_valid && !out_ready;
    out_char_next  = out_char;
    last_next      = last;
    case (phase)
      E_IDLE: begin
        if (ld.load) begin
          dig_next       = digits;
          rem_next       = REM_W'(DIG_N);
          head_char_next = ld.head_char;
          head_en_next   = ld.head_en;
          dig_en_next    = ld.dig_en;
          tail_en_next   = ld.tail_en;
          if (ld.head_en) begin
            phase_next = E_HEAD;
          end else if (ld.dig_en) begin
            phase_next = E_SKIP;
          end else if (ld.tail_en) begin
            phase_next = E_TAIL;
          end
        end
      end
      E_HEAD: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_char_next  = head_char;
          last_next      = !dig_en && !tail_en;
          if (dig_en) begin
            phase_next = E_SKIP;
          end else if (tail_en) begin
            phase_next = E_TAIL;
          end else begin
            phase_next = E_IDLE;
          end
        end
      end
      E_SKIP: begin
        // Leading zeros drop out one digit per cycle; the final digit always stays.
        if (top_dig == 4'd0 && rem != REM_W'(1)) begin
          dig_next = {dig[DIG_W-5:0], 4'd0};
          rem_next = rem - REM_W'(1);
        end else begin
          phase_next = E_DIG;
        end
      end
      E_DIG: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_char_next  = digit_ascii(top_dig);
          last_next      = (rem == REM_W'(1)) && !tail_en;
          dig_next       = {dig[DIG_W-5:0], 4'd0};
          rem_next       = rem - REM_W'(1);
          if (rem == REM_W'(1)) begin
            phase_next = tail_en ? E_TAIL : E_IDLE;
          end
        end
      end
      E_TAIL: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_char_next  = CH_CR;
          last_next      = 1'b1;
          phase_next     = E_IDLE;
        end
      end
      default: begin
        phase_next = E_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dig       <= dig_next;
    rem       <= rem_next;
    head_char <= head_char_next;
    head_en   <= head_en_next;
    dig_en    <= dig_en_next;
    tail_en   <= tail_en_next;
    out_char  <= out_char_next;
    last      <= last_next;
  end

endmodule

[design/int_to_ascii_formatter.sv]
// Top level of the formatter: item intake, sequencing and unit wiring.
//
//   channel  handshake            payload
//   input    in_valid / in_ready  req_type[1:0], value[31:0]
//   output   out_valid/out_ready  out_char[7:0], last
//
// One item is in work at a time. A raw item's first character is registered in the prefix phase,
// after the load state. Hex items drop leading zeros in the skip phase, then enter the digit phase.
// Decimal items pass through the bit-serial BCD converter and the load state to the emitter, then
// a sign phase, the skip phase and the digit phase; then one character per cycle while out_ready
// is high, and a low out_ready holds the output register. The next item is taken as soon as the
// last character sits in the output register. Reset is synchronous; an unused kind frees intake.
module int_to_ascii_formatter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [itaf_pkg::IN_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_char,
  output logic                         last
);
  import itaf_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CONV = 3'b010,
    T_LOAD = 3'b100
  } tstate_t;

  tstate_t               state, state_next;
  logic [1:0]            kind;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] opnd;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  accept;
  logic                  dab_start;
  logic                  dab_done;
  logic [BCD_W-1:0]      bcd;
  logic                  emit_idle;
  itaf_load_t            ld;
  logic [DIG_W-1:0]      digits;

  assign in_ready = (state == T_IDLE) && emit_idle;
  assign accept   = in_valid && in_ready;

  // Operand masking and two's complement magnitude for decimal items.
  assign opnd      = VALUE_BITS'(value);
  assign neg       = (req_type == REQ_DEC) && opnd[VALUE_BITS-1];
  assign mag       = neg ? (~opnd + VALUE_BITS'(1)) : opnd;
  assign dab_start = accept && (req_type == REQ_DEC);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_CHAR: state_next = T_LOAD;
            REQ_HEX:  state_next = T_LOAD;
            REQ_DEC:  state_next = T_CONV;
            default:  state_next = T_IDLE;
          endcase
        end
      end
      T_CONV: begin
        if (dab_done) begin
          state_next = T_LOAD;
        end
      end
      T_LOAD: begin
        state_next = T_IDLE;
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req_type;
      mag_r <= mag;
      neg_r <= neg;
    end
  end

  // Emitter command for the accepted item.
  always_comb begin
    ld.load      = (state == T_LOAD);
    ld.head_en   = 1'b0;
    ld.head_char = CH_MINUS;
    ld.dig_en    = 1'b1;
    ld.tail_en   = 1'b0;
    digits       = DIG_W'(bcd);
    case (kind)
      REQ_CHAR: begin
        ld.head_en   = 1'b1;
        ld.head_char = mag_r[7:0];
        ld.dig_en    = 1'b0;
        ld.tail_en   = (mag_r[7:0] == CH_LF);
      end
      REQ_HEX: begin
        digits = DIG_W'(mag_r);
      end
      default: begin
        ld.head_en = neg_r;
      end
    endcase
  end

  itaf_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (bcd)
  );

  itaf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .digits    (digits),
    .idle      (emit_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

[design/itaf_checker.sv]
// Port-level checker for the formatter and its bind statement.
`include "int_to_ascii_formatter_assert.svh"

module itaf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   req_type,
  input logic [itaf_pkg::IN_BITS-1:0] value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   out_char,
  input logic                         last
);
  import itaf_pkg::*;

  // A stalled result holds its payload.
  `ITAF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(last))

  // A stalled input item holds its payload.
  `ITAF_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(req_type) && $stable(value))

  // No new item is taken while an item still has characters to come.
  `ITAF_ASSERT_NOW(a_busy_mid, clk, rst, out_valid && !last, !in_ready)

  // An item of a known kind closes intake on the next cycle.
  `ITAF_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready && (req_type != REQ_UNUSED), !in_ready)

endmodule

bind int_to_ascii_formatter itaf_checker u_itaf_checker (.*);

[verif/ascii_output_check.sv]
`timescale 1ns / 100ps
// Channel monitor for the formatter: predicts the text of each item and checks every character.
module ascii_output_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [itaf_pkg::IN_BITS-1:0]  value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_char,
  input  logic                          last,
  output int                            mismatches,
  output int                            chars_due
);
  import itaf_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  // Characters still owed by the block, oldest first.
  text_char_t expected_text[$];

  function automatic void add_char(logic [7:0] ch, logic is_last);
    text_char_t c;
    c.ch      = ch;
    c.is_last = is_last;
    expected_text.push_back(c);
  endfunction

  // Appends the digits of a magnitude, most significant first, no leading zeros.
  function automatic void add_digits(logic [63:0] mag, logic [63:0] base);
    logic [7:0]  digs[$];
    logic [63:0] d;
    do begin
      d = mag % base;
      if (d < 64'd10) begin
        digs.push_front(CH_ZERO + d[7:0]);
      end else begin
        digs.push_front(CH_LOWA + d[7:0] - 8'd10);
      end
      mag = mag / base;
    end while (mag != 64'd0);
    foreach (digs[i]) add_char(digs[i], i == digs.size() - 1);
  endfunction

  // Works out the full text of one accepted item.
  function automatic void predict_text(logic [1:0] kind, logic [IN_BITS-1:0] v);
    logic [63:0] mask;
    logic [63:0] operand;
    mask    = (64'd1 << VALUE_BITS) - 64'd1;
    operand = 64'(v) & mask;
    case (kind)
      REQ_CHAR: begin
        // A line feed is followed by a carriage return.
        if (operand[7:0] == CH_LF) begin
          add_char(CH_LF, 1'b0);
          add_char(CH_CR, 1'b1);
        end else begin
          add_char(operand[7:0], 1'b1);
        end
      end
      REQ_HEX: begin
        add_digits(operand, 64'd16);
      end
      REQ_DEC: begin
        // Negative operands print a sign, then the magnitude as unsigned.
        if (operand[VALUE_BITS-1]) begin
          add_char(CH_MINUS, 1'b0);
          operand = (64'd0 - operand) & mask;
        end
        add_digits(operand, 64'd10);
      end
      default: begin
        // The unused kind produces no text.
      end
    endcase
  endfunction

  // Predict on each accepted item and compare each accepted character.
  always @(posedge clk) begin : watch
    text_char_t want;
    int         errs;
    errs = 0;
    if (rst) begin
      expected_text.delete();
      mismatches <= 0;
      chars_due  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(req_type, value);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character: out_char 8'h%02h, last %0b", out_char, last);
          errs++;
        end else begin
          want = expected_text.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected 8'h%02h, got 8'h%02h", want.ch, out_char);
            errs++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0b, got %0b", want.is_last, last);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
      chars_due  <= expected_text.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Top of the formatter testbench: clock, reset, item stimulus, output stalls and the verdict.
module testbench;
  import itaf_pkg::*;

  localparam int RUN_LIMIT  = 500000;
  localparam int DRAIN_WAIT = 100;
  localparam int MAX_GAP    = 40;
  localparam int PHASE_ITEMS = 39;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               out_ready = 1'b0;
  logic [1:0]         req_type  = REQ_CHAR;
  logic [IN_BITS-1:0] value     = '0;
  logic               in_ready;
  logic               out_valid;
  logic [7:0]         out_char;
  logic               last;
  int                 mismatches;
  int                 chars_due;
  int                 cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int_to_ascii_formatter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

  ascii_output_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last       (last),
    .mismatches (mismatches),
    .chars_due  (chars_due)
  );

  // The receiver stalls at random with the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_item(input logic [1:0] kind, input logic [IN_BITS-1:0] v);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      req_type <= 2'($urandom_range(3));
      value    <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every owed character has come out.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
  endtask

  // One random item: mostly valid kinds, values biased toward interesting ranges.
  task automatic send_random_item();
    logic [1:0]         kind;
    logic [IN_BITS-1:0] v;
    if ($urandom_range(99) < 8) begin
      kind = REQ_UNUSED;
    end else begin
      kind = 2'($urandom_range(2));
    end
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(255);
      2: v = 32'd0 - $urandom_range(1000);
      3: v = (32'd1 << $urandom_range(31)) - $urandom_range(1);
      4: v = {24'($urandom), CH_LF};
      default: v = $urandom >> $urandom_range(31);
    endcase
    send_item(kind, v);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items: field extremes, line feed handling, sign edges, unused kind.
    send_item(REQ_CHAR, 32'h0000_0000);
    send_item(REQ_CHAR, 32'hFFFF_FFFF);
    send_item(REQ_CHAR, 32'h0000_000A);
    send_item(REQ_CHAR, 32'hFFFF_FF0A);
    send_item(REQ_CHAR, 32'h0000_010A);
    send_item(REQ_CHAR, 32'h0000_000D);
    send_item(REQ_CHAR, 32'h0000_0041);
    send_item(REQ_HEX,  32'h0000_0000);
    send_item(REQ_HEX,  32'hFFFF_FFFF);
    send_item(REQ_HEX,  32'h0000_0001);
    send_item(REQ_HEX,  32'h0000_0010);
    send_item(REQ_HEX,  32'hABCD_EF09);
    send_item(REQ_HEX,  32'h8000_0000);
    send_item(REQ_DEC,  32'h0000_0000);
    send_item(REQ_DEC,  32'h0000_0001);
    send_item(REQ_DEC,  32'hFFFF_FFFF);
    send_item(REQ_DEC,  32'h7FFF_FFFF);
    send_item(REQ_DEC,  32'h8000_0000);
    send_item(REQ_DEC,  32'h0000_000A);
    send_item(REQ_DEC,  32'hFFFF_FFF6);
    send_item(REQ_DEC,  32'h3B9A_CA00);
    send_item(REQ_UNUSED, 32'h0000_0000);
    send_item(REQ_UNUSED, 32'hFFFF_FFFF);
    send_item(REQ_HEX,  32'h0000_00FF);
    hold_until_drained();

    // Random items under each idle pattern.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
      hold_until_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
